// File: design/cvg_pkg.sv
// Shared constants and types of the cube sphere vertex generator.
package cvg_pkg;

   localparam int DIV_BITS_DEFAULT      = 8;
   localparam int POS_FRAC_BITS_DEFAULT = 14;
   localparam int DIV_RESET_VALUE       = 8;

   localparam int COLOR_W = 24;
   localparam int INDEX_W = 19;
   localparam int POS_W   = 16;
   localparam int TEX_W   = 16;
   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;

   localparam logic [2:0] FACE_NEG_Z = 3'd0;
   localparam logic [2:0] FACE_POS_Z = 3'd1;
   localparam logic [2:0] FACE_NEG_X = 3'd2;
   localparam logic [2:0] FACE_POS_X = 3'd3;
   localparam logic [2:0] FACE_NEG_Y = 3'd4;
   localparam logic [2:0] FACE_POS_Y = 3'd5;

   localparam logic [2:0] REG_DIVISIONS   = 3'd0;
   localparam logic [2:0] REG_COLOR_NEG_Z = 3'd1;
   localparam logic [2:0] REG_COLOR_POS_Z = 3'd2;
   localparam logic [2:0] REG_COLOR_NEG_X = 3'd3;
   localparam logic [2:0] REG_COLOR_POS_X = 3'd4;
   localparam logic [2:0] REG_COLOR_NEG_Y = 3'd5;
   localparam logic [2:0] REG_COLOR_POS_Y = 3'd6;

   typedef struct packed {
      logic       valid;
      logic       bad;
      logic [2:0] neg;
   } ctl_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [INDEX_W-1:0] index;
   } side_type;

endpackage

// File: design/cvg_csr.sv
// Configuration registers with APB-style access.
module cvg_csr #(
   parameter int DIV_BITS = cvg_pkg::DIV_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cvg_pkg::PADDR_W-1:0]   paddr,
   input  logic [cvg_pkg::PDATA_W-1:0]   pwdata,
   output logic [cvg_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready,
   output logic [DIV_BITS-1:0]           divisions,
   output logic [5:0][cvg_pkg::COLOR_W-1:0] colors
);
   localparam logic [DIV_BITS-1:0] DIV_RESET = DIV_BITS'(cvg_pkg::DIV_RESET_VALUE);

   logic [DIV_BITS-1:0]                  divisions_ff;
   logic [5:0][cvg_pkg::COLOR_W-1:0]     colors_ff;
   logic [2:0]                           reg_index;
   logic                                 write_en;

   assign reg_index = paddr[4:2];
   assign write_en  = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign divisions = divisions_ff;
   assign colors    = colors_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisions_ff <= DIV_RESET;
         colors_ff    <= '0;
      end else if (write_en) begin
         case (reg_index)
            cvg_pkg::REG_DIVISIONS:   divisions_ff <= pwdata[DIV_BITS-1:0];
            cvg_pkg::REG_COLOR_NEG_Z: colors_ff[0] <= pwdata[cvg_pkg::COLOR_W-1:0];
            cvg_pkg::REG_COLOR_POS_Z: colors_ff[1] <= pwdata[cvg_pkg::COLOR_W-1:0];
            cvg_pkg::REG_COLOR_NEG_X: colors_ff[2] <= pwdata[cvg_pkg::COLOR_W-1:0];
            cvg_pkg::REG_COLOR_POS_X: colors_ff[3] <= pwdata[cvg_pkg::COLOR_W-1:0];
            cvg_pkg::REG_COLOR_NEG_Y: colors_ff[4] <= pwdata[cvg_pkg::COLOR_W-1:0];
            cvg_pkg::REG_COLOR_POS_Y: colors_ff[5] <= pwdata[cvg_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_index)
         cvg_pkg::REG_DIVISIONS:   prdata = cvg_pkg::PDATA_W'(divisions_ff);
         cvg_pkg::REG_COLOR_NEG_Z: prdata = cvg_pkg::PDATA_W'(colors_ff[0]);
         cvg_pkg::REG_COLOR_POS_Z: prdata = cvg_pkg::PDATA_W'(colors_ff[1]);
         cvg_pkg::REG_COLOR_NEG_X: prdata = cvg_pkg::PDATA_W'(colors_ff[2]);
         cvg_pkg::REG_COLOR_POS_X: prdata = cvg_pkg::PDATA_W'(colors_ff[3]);
         cvg_pkg::REG_COLOR_NEG_Y: prdata = cvg_pkg::PDATA_W'(colors_ff[4]);
         cvg_pkg::REG_COLOR_POS_Y: prdata = cvg_pkg::PDATA_W'(colors_ff[5]);
         default:                  prdata = '0;
      endcase
   end

endmodule

// File: design/cvg_front.sv
// Front pipeline: request check, cube vector, squares, sum and vertex index.
module cvg_front #(
   parameter int DIV_BITS      = cvg_pkg::DIV_BITS_DEFAULT,
   parameter int POS_FRAC_BITS = cvg_pkg::POS_FRAC_BITS_DEFAULT,
   localparam int SW = 2*DIV_BITS + 2,
   localparam int NW = 2*DIV_BITS + 2*POS_FRAC_BITS + 2,
   localparam int TW = DIV_BITS + 17
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [2:0]                       face,
   input  logic [DIV_BITS-1:0]              grid_row,
   input  logic [DIV_BITS-1:0]              grid_col,
   input  logic [DIV_BITS-1:0]              divisions,
   input  logic [5:0][cvg_pkg::COLOR_W-1:0] colors,
   output cvg_pkg::ctl_type                 ctl,
   output cvg_pkg::side_type                side,
   output logic [SW-1:0]                    sum_sq,
   output logic [DIV_BITS:0]                div2,
   output logic [2:0][NW-1:0]               rem_init,
   output logic [1:0][TW-1:0]               tnum
);
   localparam int DB = DIV_BITS;

   // stage A: capture and check
   logic                         a_valid_ff;
   logic                         a_bad_ff, a_bad_in;
   logic [2:0]                   a_face_ff;
   logic [DB-1:0]                a_row_ff, a_col_ff, a_d_ff;
   logic [cvg_pkg::COLOR_W-1:0]  a_color_ff, a_color_in;

   always_comb begin
      a_bad_in = (face > cvg_pkg::FACE_POS_Y) || (divisions == '0) ||
                 (grid_row > divisions) || (grid_col > divisions);
      case (face)
         cvg_pkg::FACE_NEG_Z: a_color_in = colors[0];
         cvg_pkg::FACE_POS_Z: a_color_in = colors[1];
         cvg_pkg::FACE_NEG_X: a_color_in = colors[2];
         cvg_pkg::FACE_POS_X: a_color_in = colors[3];
         cvg_pkg::FACE_NEG_Y: a_color_in = colors[4];
         cvg_pkg::FACE_POS_Y: a_color_in = colors[5];
         default:             a_color_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else       a_valid_ff <= accept;
      a_bad_ff   <= a_bad_in;
      a_face_ff  <= face;
      a_row_ff   <= grid_row;
      a_col_ff   <= grid_col;
      a_d_ff     <= divisions;
      a_color_ff <= a_color_in;
   end

   // stage B: component magnitudes and signs
   logic                         b_valid_ff, b_bad_ff;
   logic [2:0]                   b_neg_ff, b_neg_in;
   logic [2:0][DB-1:0]           b_mag_ff, b_mag_in;
   logic [2:0]                   b_face_ff;
   logic [DB-1:0]                b_row_ff, b_col_ff;
   logic [DB:0]                  b_side_ff, b_div2_ff;
   logic [1:0][TW-1:0]           b_tnum_ff;
   logic [cvg_pkg::COLOR_W-1:0]  b_color_ff;
   logic [DB:0]                  twice_a, twice_b, d_ext, diff_a, diff_b;
   logic                         neg_a, neg_b, neg_e;

   always_comb begin
      twice_a = {a_col_ff, 1'b0};
      twice_b = {a_row_ff, 1'b0};
      d_ext   = {1'b0, a_d_ff};
      neg_a   = twice_a < d_ext;
      neg_b   = twice_b < d_ext;
      neg_e   = ~a_face_ff[0];
      diff_a  = neg_a ? (d_ext - twice_a) : (twice_a - d_ext);
      diff_b  = neg_b ? (d_ext - twice_b) : (twice_b - d_ext);
      case (a_face_ff)
         cvg_pkg::FACE_NEG_Z, cvg_pkg::FACE_POS_Z: begin
            b_mag_in = {a_d_ff, diff_b[DB-1:0], diff_a[DB-1:0]};
            b_neg_in = {neg_e, neg_b, neg_a};
         end
         cvg_pkg::FACE_NEG_X, cvg_pkg::FACE_POS_X: begin
            b_mag_in = {diff_a[DB-1:0], diff_b[DB-1:0], a_d_ff};
            b_neg_in = {neg_a, neg_b, neg_e};
         end
         default: begin
            b_mag_in = {diff_b[DB-1:0], a_d_ff, diff_a[DB-1:0]};
            b_neg_in = {neg_b, neg_e, neg_a};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else       b_valid_ff <= a_valid_ff;
      b_bad_ff     <= a_bad_ff;
      b_neg_ff     <= b_neg_in;
      b_mag_ff     <= b_mag_in;
      b_face_ff    <= a_face_ff;
      b_row_ff     <= a_row_ff;
      b_col_ff     <= a_col_ff;
      b_side_ff    <= (DB+1)'(a_d_ff) + (DB+1)'(1);
      b_div2_ff    <= {a_d_ff, 1'b0};
      b_tnum_ff[0] <= {a_col_ff, 16'd0} + TW'(a_d_ff);
      b_tnum_ff[1] <= {a_row_ff, 16'd0} + TW'(a_d_ff);
      b_color_ff   <= a_color_ff;
   end

   // stage C: squares and index products
   logic                         c_valid_ff, c_bad_ff;
   logic [2:0]                   c_neg_ff, c_face_ff;
   logic [2:0][2*DB-1:0]         c_sq_ff;
   logic [2*DB+1:0]              c_side2_ff;
   logic [2*DB:0]                c_rowside_ff;
   logic [DB-1:0]                c_col_ff;
   logic [DB:0]                  c_div2_ff;
   logic [1:0][TW-1:0]           c_tnum_ff;
   logic [cvg_pkg::COLOR_W-1:0]  c_color_ff;

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else       c_valid_ff <= b_valid_ff;
      c_bad_ff     <= b_bad_ff;
      c_neg_ff     <= b_neg_ff;
      c_face_ff    <= b_face_ff;
      for (int i = 0; i < 3; i++) begin
         c_sq_ff[i] <= (2*DB)'(b_mag_ff[i]) * (2*DB)'(b_mag_ff[i]);
      end
      c_side2_ff   <= (2*DB+2)'(b_side_ff) * (2*DB+2)'(b_side_ff);
      c_rowside_ff <= (2*DB+1)'(b_row_ff) * (2*DB+1)'(b_side_ff);
      c_col_ff     <= b_col_ff;
      c_div2_ff    <= b_div2_ff;
      c_tnum_ff    <= b_tnum_ff;
      c_color_ff   <= b_color_ff;
   end

   // stage D: sum of squares, scaled targets, flat index
   cvg_pkg::ctl_type   ctl_ff;
   cvg_pkg::side_type  side_ff;
   logic [SW-1:0]      sum_ff;
   logic [DB:0]        div2_ff;
   logic [2:0][NW-1:0] rem_ff;
   logic [1:0][TW-1:0] tnum_ff;
   logic [2*DB+4:0]    index_in;

   assign index_in = (2*DB+5)'(c_face_ff) * (2*DB+5)'(c_side2_ff)
                   + (2*DB+5)'(c_rowside_ff) + (2*DB+5)'(c_col_ff);

   always_ff @(posedge clock) begin
      if (reset) ctl_ff.valid <= 1'b0;
      else       ctl_ff.valid <= c_valid_ff;
      ctl_ff.bad    <= c_bad_ff;
      ctl_ff.neg    <= c_neg_ff;
      side_ff.color <= c_color_ff;
      side_ff.index <= cvg_pkg::INDEX_W'(index_in);
      sum_ff        <= SW'(c_sq_ff[0]) + SW'(c_sq_ff[1]) + SW'(c_sq_ff[2]);
      for (int i = 0; i < 3; i++) begin
         rem_ff[i] <= NW'(c_sq_ff[i]) << (2*POS_FRAC_BITS + 2);
      end
      div2_ff <= c_div2_ff;
      tnum_ff <= c_tnum_ff;
   end

   assign ctl      = ctl_ff;
   assign side     = side_ff;
   assign sum_sq   = sum_ff;
   assign div2     = div2_ff;
   assign rem_init = rem_ff;
   assign tnum     = tnum_ff;

endmodule

// File: design/cvg_step.sv
// One bit of the normalize recurrence and one bit of the texture divide.
module cvg_step #(
   parameter int DIV_BITS      = cvg_pkg::DIV_BITS_DEFAULT,
   parameter int POS_FRAC_BITS = cvg_pkg::POS_FRAC_BITS_DEFAULT,
   parameter int BIT_POS       = 0,
   localparam int SW = 2*DIV_BITS + 2,
   localparam int NW = 2*DIV_BITS + 2*POS_FRAC_BITS + 2,
   localparam int QW = POS_FRAC_BITS + 2 + SW,
   localparam int MW = POS_FRAC_BITS + 2,
   localparam int TW = DIV_BITS + 17
) (
   input  logic                clock,
   input  logic                reset,
   input  cvg_pkg::ctl_type    ctl_in,
   input  cvg_pkg::side_type   side_in,
   input  logic [SW-1:0]       sum_in,
   input  logic [DIV_BITS:0]   div2_in,
   input  logic [2:0][NW-1:0]  rem_in,
   input  logic [2:0][QW-1:0]  acc_in,
   input  logic [2:0][MW-1:0]  root_in,
   input  logic [1:0][TW-1:0]  trem_in,
   input  logic [1:0][15:0]    tq_in,
   output cvg_pkg::ctl_type    ctl_out,
   output cvg_pkg::side_type   side_out,
   output logic [SW-1:0]       sum_out,
   output logic [DIV_BITS:0]   div2_out,
   output logic [2:0][NW-1:0]  rem_out,
   output logic [2:0][QW-1:0]  acc_out,
   output logic [2:0][MW-1:0]  root_out,
   output logic [1:0][TW-1:0]  trem_out,
   output logic [1:0][15:0]    tq_out
);
   localparam int DW = 2*DIV_BITS + 2*POS_FRAC_BITS + 8;

   cvg_pkg::ctl_type   ctl_ff;
   cvg_pkg::side_type  side_ff;
   logic [SW-1:0]      sum_ff;
   logic [DIV_BITS:0]  div2_ff;
   logic [2:0][NW-1:0] rem_ff, rem_in2;
   logic [2:0][QW-1:0] acc_ff, acc_in2;
   logic [2:0][MW-1:0] root_ff, root_in2;
   logic [1:0][TW-1:0] trem_ff, trem_in2;
   logic [1:0][15:0]   tq_ff, tq_in2;

   generate
      if (BIT_POS <= POS_FRAC_BITS + 1) begin : g_root
         logic [2:0][DW-1:0] delta;
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               // try setting this root bit: (m + 2^k)^2 s - m^2 s
               delta[i]    = (DW'(acc_in[i]) << (BIT_POS + 1))
                           + (DW'(sum_in) << (2*BIT_POS));
               rem_in2[i]  = rem_in[i];
               acc_in2[i]  = acc_in[i];
               root_in2[i] = root_in[i];
               if (delta[i] <= DW'(rem_in[i])) begin
                  rem_in2[i]           = rem_in[i] - NW'(delta[i]);
                  acc_in2[i]           = acc_in[i] + (QW'(sum_in) << BIT_POS);
                  root_in2[i][BIT_POS] = 1'b1;
               end
            end
         end
      end else begin : g_root_pass
         assign rem_in2  = rem_in;
         assign acc_in2  = acc_in;
         assign root_in2 = root_in;
      end

      if (BIT_POS <= 15) begin : g_div
         logic [TW-1:0] shifted;
         assign shifted = TW'(div2_in) << BIT_POS;
         always_comb begin
            for (int i = 0; i < 2; i++) begin
               trem_in2[i] = trem_in[i];
               tq_in2[i]   = tq_in[i];
               if (trem_in[i] >= shifted) begin
                  trem_in2[i]        = trem_in[i] - shifted;
                  tq_in2[i][BIT_POS] = 1'b1;
               end
            end
         end
      end else begin : g_div_pass
         assign trem_in2 = trem_in;
         assign tq_in2   = tq_in;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) ctl_ff.valid <= 1'b0;
      else       ctl_ff.valid <= ctl_in.valid;
      ctl_ff.bad  <= ctl_in.bad;
      ctl_ff.neg  <= ctl_in.neg;
      side_ff     <= side_in;
      sum_ff      <= sum_in;
      div2_ff     <= div2_in;
      rem_ff      <= rem_in2;
      acc_ff      <= acc_in2;
      root_ff     <= root_in2;
      trem_ff     <= trem_in2;
      tq_ff       <= tq_in2;
   end

   assign ctl_out  = ctl_ff;
   assign side_out = side_ff;
   assign sum_out  = sum_ff;
   assign div2_out = div2_ff;
   assign rem_out  = rem_ff;
   assign acc_out  = acc_ff;
   assign root_out = root_ff;
   assign trem_out = trem_ff;
   assign tq_out   = tq_ff;

endmodule

// File: design/cube_sphere_vertex_generator_top.sv
// Top level of the cube sphere vertex generator.
//
//  - Request channel: drive req_face, req_grid_row and req_grid_col with start
//    high; the item is taken at any edge where start is high and busy is low.
//    busy stays low, so a new item may be issued in every cycle.
//  - Result channel: rsp_valid marks one cycle holding one result item; the
//    receiver takes it in that cycle and cannot stall the pipe.
//  - Pipeline: front stages A to D, the recurrence stages, then the output
//    register that drives the result strobe.
//  - Throughput: one item per cycle. Each stage of the recurrence decides
//    one bit of the scaled square root (per axis) and one quotient bit of
//    each texture coordinate; the stage count sets the latency.
//  - Normalize: each axis finds m = floor(2|v|*2^F / sqrt(s)) bit by bit
//    with shift-add updates of m^2*s and m*s, then rounds with (m+1)/2.
//  - Configuration: APB-style registers (divisions, six face colors), to be
//    written only while no item is in flight.
//  - Reset: drains every valid bit; registers return to divisions = 8 and
//    black face colors.
//  - Rejected items (bad face, row or column above divisions, divisions of
//    zero) leave with bad_request set and all other fields zero.
module cube_sphere_vertex_generator_top #(
   parameter int DIV_BITS      = cvg_pkg::DIV_BITS_DEFAULT,
   parameter int POS_FRAC_BITS = cvg_pkg::POS_FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [2:0]                      req_face,
   input  logic [DIV_BITS-1:0]             req_grid_row,
   input  logic [DIV_BITS-1:0]             req_grid_col,
   output logic                            rsp_valid,
   output logic [cvg_pkg::POS_W-1:0]       rsp_pos_x,
   output logic [cvg_pkg::POS_W-1:0]       rsp_pos_y,
   output logic [cvg_pkg::POS_W-1:0]       rsp_pos_z,
   output logic [cvg_pkg::TEX_W-1:0]       rsp_tex_s,
   output logic [cvg_pkg::TEX_W-1:0]       rsp_tex_t,
   output logic [cvg_pkg::COLOR_W-1:0]     rsp_vertex_color,
   output logic [cvg_pkg::INDEX_W-1:0]     rsp_vertex_index,
   output logic                            rsp_bad_request,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cvg_pkg::PADDR_W-1:0]     paddr,
   input  logic [cvg_pkg::PDATA_W-1:0]     pwdata,
   output logic [cvg_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready
);
   localparam int SW = 2*DIV_BITS + 2;
   localparam int NW = 2*DIV_BITS + 2*POS_FRAC_BITS + 2;
   localparam int QW = POS_FRAC_BITS + 2 + SW;
   localparam int MW = POS_FRAC_BITS + 2;
   localparam int TW = DIV_BITS + 17;
   localparam int L  = (POS_FRAC_BITS + 2 > 16) ? POS_FRAC_BITS + 2 : 16;

   logic [DIV_BITS-1:0]                  divisions;
   logic [5:0][cvg_pkg::COLOR_W-1:0]     colors;
   logic                                 accept;

   // the pipe never holds off a request
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   cvg_csr #(.DIV_BITS(DIV_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .divisions (divisions),
      .colors    (colors)
   );

   // stage chain wiring; index 0 is the front output
   cvg_pkg::ctl_type   ctl_w  [0:L];
   cvg_pkg::side_type  side_w [0:L];
   logic [SW-1:0]      sum_w  [0:L];
   logic [DIV_BITS:0]  div2_w [0:L];
   logic [2:0][NW-1:0] rem_w  [0:L];
   logic [2:0][QW-1:0] acc_w  [0:L];
   logic [2:0][MW-1:0] root_w [0:L];
   logic [1:0][TW-1:0] trem_w [0:L];
   logic [1:0][15:0]   tq_w   [0:L];

   cvg_front #(.DIV_BITS(DIV_BITS), .POS_FRAC_BITS(POS_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .face      (req_face),
      .grid_row  (req_grid_row),
      .grid_col  (req_grid_col),
      .divisions (divisions),
      .colors    (colors),
      .ctl       (ctl_w[0]),
      .side      (side_w[0]),
      .sum_sq    (sum_w[0]),
      .div2      (div2_w[0]),
      .rem_init  (rem_w[0]),
      .tnum      (trem_w[0])
   );

   // recurrences start from an empty root and quotient
   assign acc_w[0]  = '0;
   assign root_w[0] = '0;
   assign tq_w[0]   = '0;

   // one stage per bit, most significant bit first
   generate
      for (genvar j = 0; j < L; j++) begin : g_stage
         cvg_step #(
            .DIV_BITS      (DIV_BITS),
            .POS_FRAC_BITS (POS_FRAC_BITS),
            .BIT_POS       (L - 1 - j)
         ) u_step (
            .clock    (clock),
            .reset    (reset),
            .ctl_in   (ctl_w[j]),
            .side_in  (side_w[j]),
            .sum_in   (sum_w[j]),
            .div2_in  (div2_w[j]),
            .rem_in   (rem_w[j]),
            .acc_in   (acc_w[j]),
            .root_in  (root_w[j]),
            .trem_in  (trem_w[j]),
            .tq_in    (tq_w[j]),
            .ctl_out  (ctl_w[j+1]),
            .side_out (side_w[j+1]),
            .sum_out  (sum_w[j+1]),
            .div2_out (div2_w[j+1]),
            .rem_out  (rem_w[j+1]),
            .acc_out  (acc_w[j+1]),
            .root_out (root_w[j+1]),
            .trem_out (trem_w[j+1]),
            .tq_out   (tq_w[j+1])
         );
      end
   endgenerate

   // output stage: round, apply sign, zero rejected items
   logic                                rsp_valid_ff;
   logic [2:0][cvg_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [1:0][cvg_pkg::TEX_W-1:0]      tex_ff, tex_in;
   logic [cvg_pkg::COLOR_W-1:0]         color_ff, color_in;
   logic [cvg_pkg::INDEX_W-1:0]         index_ff, index_in;
   logic                                bad_ff;
   logic [2:0][MW-1:0]                  rounded;
   logic [2:0][31:0]                    signed_val;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rounded[i]    = (root_w[L][i] + MW'(1)) >> 1;
         signed_val[i] = ctl_w[L].neg[i] ? (32'd0 - 32'(rounded[i])) : 32'(rounded[i]);
         pos_in[i]     = ctl_w[L].bad ? '0 : signed_val[i][cvg_pkg::POS_W-1:0];
      end
      tex_in   = ctl_w[L].bad ? '0 : tq_w[L];
      color_in = ctl_w[L].bad ? '0 : side_w[L].color;
      index_in = ctl_w[L].bad ? '0 : side_w[L].index;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= ctl_w[L].valid;
      pos_ff   <= pos_in;
      tex_ff   <= tex_in;
      color_ff <= color_in;
      index_ff <= index_in;
      bad_ff   <= ctl_w[L].bad;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_ff[0];
   assign rsp_pos_y        = pos_ff[1];
   assign rsp_pos_z        = pos_ff[2];
   assign rsp_tex_s        = tex_ff[0];
   assign rsp_tex_t        = tex_ff[1];
   assign rsp_vertex_color = color_ff;
   assign rsp_vertex_index = index_ff;
   assign rsp_bad_request  = bad_ff;

endmodule

// File: test/tb.sv
// Self-checking testbench of the cube sphere vertex generator.
`timescale 1ns / 100ps

module tb;

   localparam int LATENCY = 21;

   typedef struct {
      logic [cvg_pkg::POS_W-1:0]   pos_x, pos_y, pos_z;
      logic [cvg_pkg::TEX_W-1:0]   tex_s, tex_t;
      logic [cvg_pkg::COLOR_W-1:0] color;
      logic [cvg_pkg::INDEX_W-1:0] index;
      logic                        bad;
   } vertex_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid;
   logic [2:0] req_face = 0;
   logic [7:0] req_grid_row = 0, req_grid_col = 0;
   logic [cvg_pkg::POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [cvg_pkg::TEX_W-1:0] rsp_tex_s, rsp_tex_t;
   logic [cvg_pkg::COLOR_W-1:0] rsp_vertex_color;
   logic [cvg_pkg::INDEX_W-1:0] rsp_vertex_index;
   logic rsp_bad_request;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [cvg_pkg::PADDR_W-1:0] paddr = 0;
   logic [cvg_pkg::PDATA_W-1:0] pwdata = 0, prdata;
   logic pready;

   cube_sphere_vertex_generator_top dut (.*);

   initial forever #5 clock = ~clock;

   // Register shadow used by the predictor.
   logic [7:0]                  cur_div = 8'd8;
   logic [cvg_pkg::COLOR_W-1:0] cur_color [6] = '{default: '0};

   vertex_type pending_vertices [$];
   int         taken = 0, results = 0, errors = 0, bad_seen = 0;

   // Round half away from zero of |a|*2^14/sqrt(s), found by bisection.
   function automatic logic [cvg_pkg::POS_W-1:0] unit_axis(longint a, longint unsigned s);
      longint unsigned mag, a2, lo, hi, mid, odd;
      mag = (a < 0) ? -a : a;
      a2 = mag * mag;
      lo = 0;
      hi = 64'd1 << cvg_pkg::POS_FRAC_BITS_DEFAULT;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2 * mid - 1;
         if (odd * odd * s <= ((4 * a2) << (2 * cvg_pkg::POS_FRAC_BITS_DEFAULT))) lo = mid;
         else hi = mid - 1;
      end
      if (a < 0) lo = -lo;
      return lo[cvg_pkg::POS_W-1:0];
   endfunction

   function automatic logic [cvg_pkg::TEX_W-1:0] tex_ratio(longint unsigned n,
                                                           longint unsigned d);
      longint unsigned q;
      q = (n * 65536 + d) / (2 * d);
      return q[cvg_pkg::TEX_W-1:0];
   endfunction

   function automatic vertex_type predict_vertex(logic [2:0] face, logic [7:0] row,
                                                 logic [7:0] col);
      vertex_type v;
      longint a, b, e, d, vx, vy, vz, side, idx;
      longint unsigned s;
      v = '{default: '0};
      d = cur_div;
      if (face > cvg_pkg::FACE_POS_Y || d == 0 || row > d || col > d) begin
         v.bad = 1'b1;
         return v;
      end
      a = 2 * longint'(col) - d;
      b = 2 * longint'(row) - d;
      e = face[0] ? d : -d;
      if (face < cvg_pkg::FACE_NEG_X) begin
         vx = a; vy = b; vz = e;
      end else if (face < cvg_pkg::FACE_NEG_Y) begin
         vx = e; vy = b; vz = a;
      end else begin
         vx = a; vy = e; vz = b;
      end
      s = vx * vx + vy * vy + vz * vz;
      v.pos_x = unit_axis(vx, s);
      v.pos_y = unit_axis(vy, s);
      v.pos_z = unit_axis(vz, s);
      v.tex_s = tex_ratio(col, d);
      v.tex_t = tex_ratio(row, d);
      v.color = cur_color[face];
      side = d + 1;
      idx = face * side * side + row * side + col;
      v.index = idx[cvg_pkg::INDEX_W-1:0];
      return v;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("MISMATCH result %0d %s: got %0h want %0h", results, what, got, want);
   endtask

   // Queue a prediction per taken item; check each strobed result against the oldest.
   always @(posedge clock) begin
      vertex_type w;
      if (!reset && start && !busy) begin
         pending_vertices.insert(pending_vertices.size(),
                                 predict_vertex(req_face, req_grid_row, req_grid_col));
         taken++;
      end
      if (!reset && rsp_valid) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            w = pending_vertices.pop_front();
            if (rsp_pos_x !== w.pos_x) report_mismatch("pos_x", rsp_pos_x, w.pos_x);
            if (rsp_pos_y !== w.pos_y) report_mismatch("pos_y", rsp_pos_y, w.pos_y);
            if (rsp_pos_z !== w.pos_z) report_mismatch("pos_z", rsp_pos_z, w.pos_z);
            if (rsp_tex_s !== w.tex_s) report_mismatch("tex_s", rsp_tex_s, w.tex_s);
            if (rsp_tex_t !== w.tex_t) report_mismatch("tex_t", rsp_tex_t, w.tex_t);
            if (rsp_vertex_color !== w.color)
               report_mismatch("vertex_color", rsp_vertex_color, w.color);
            if (rsp_vertex_index !== w.index)
               report_mismatch("vertex_index", rsp_vertex_index, w.index);
            if (rsp_bad_request !== w.bad)
               report_mismatch("bad_request", rsp_bad_request, w.bad);
            if (w.bad) bad_seen++;
         end
         results++;
      end
   end

   // Send one item and hold start for it; lower start when a gap follows.
   task automatic send_vertex(logic [2:0] face, logic [7:0] row, logic [7:0] col, int gap);
      int n;
      n = taken;
      @(negedge clock);
      start = 1;
      req_face = face;
      req_grid_row = row;
      req_grid_col = col;
      wait (taken != n);
      if (gap > 0) begin
         @(negedge clock);
         start = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drop start and wait until every predicted result has come out.
   task automatic drain();
      @(negedge clock);
      start = 0;
      wait (pending_vertices.size() == 0);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      psel = 1; pwrite = 1; penable = 0;
      paddr = cvg_pkg::PADDR_W'(idx) << 2;
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      if (idx == cvg_pkg::REG_DIVISIONS) cur_div = value[7:0];
      else cur_color[idx - 1] = value[cvg_pkg::COLOR_W-1:0];
   endtask

   task automatic write_colors(logic [cvg_pkg::COLOR_W-1:0] base);
      for (int k = 0; k < 6; k++)
         write_reg(3'(cvg_pkg::REG_COLOR_NEG_Z + k),
                   {8'hA5, base ^ 24'(24'h111111 * k)});
   endtask

   // Corners, centers and every face including the two invalid codes at reset settings.
   task automatic test_reset_defaults();
      for (int f = 0; f < 8; f++) begin
         send_vertex(3'(f), 0, 0, 0);
         send_vertex(3'(f), 8, 8, 1);
         send_vertex(3'(f), 4, 4, 0);
      end
      drain();
   endtask

   // Range limits: row or column one past divisions, full-scale values, divisions of zero.
   task automatic test_field_extremes();
      write_colors(24'hFFFFFF);
      send_vertex(cvg_pkg::FACE_POS_X, 9, 0, 0);
      send_vertex(cvg_pkg::FACE_NEG_Y, 0, 9, 0);
      send_vertex(cvg_pkg::FACE_POS_Y, 8, 3, 2);
      send_vertex(3'd7, 255, 255, 1);
      drain();
      write_reg(cvg_pkg::REG_DIVISIONS, 32'h0000_00FF);
      send_vertex(cvg_pkg::FACE_POS_Y, 255, 255, 0);
      send_vertex(cvg_pkg::FACE_NEG_Z, 255, 0, 0);
      send_vertex(cvg_pkg::FACE_POS_X, 127, 128, 1);
      drain();
      write_reg(cvg_pkg::REG_DIVISIONS, 32'hFFFF_FF01);
      send_vertex(cvg_pkg::FACE_NEG_X, 1, 1, 0);
      send_vertex(cvg_pkg::FACE_POS_Z, 0, 2, 1);
      drain();
      write_reg(cvg_pkg::REG_DIVISIONS, 0);
      send_vertex(cvg_pkg::FACE_NEG_Z, 0, 0, 1);
      drain();
   endtask

   // Random settings; mostly in-range vertices with a share of rejected ones.
   task automatic test_random_stream(int count);
      int d, f, r, c;
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) begin
            drain();
            case ($urandom_range(0, 4))
               0: d = 255;
               1: d = 1;
               2: d = $urandom_range(2, 16);
               default: d = $urandom_range(1, 255);
            endcase
            write_reg(cvg_pkg::REG_DIVISIONS, d);
            write_colors(24'($urandom));
         end
         if (i == count / 2) drain();
         f = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
         r = $urandom_range(0, d);
         c = $urandom_range(0, d);
         if ($urandom_range(0, 15) == 0) r = $urandom_range(0, 255);
         if ($urandom_range(0, 15) == 0) c = $urandom_range(0, 255);
         send_vertex(3'(f), 8'(r), 8'(c), (i % 300 < 60) ? 0 : pick_gap());
      end
      drain();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 0;
      test_reset_defaults();
      test_field_extremes();
      test_random_stream(1450);
      $display("Covered %0d items (%0d rejected) over several division and color settings.",
               results, bad_seen);
      if (errors == 0 && pending_vertices.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d results still pending.", pending_vertices.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
